// ===== rtl/iee_pkg.sv =====
// shared types, character codes and helpers of the expression evaluator
`timescale 1ns / 1ps

package iee_pkg;

    localparam int OUT_WIDTH = 32;

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        CC_DIGIT,
        CC_MULDIV,
        CC_ADDSUB,
        CC_EQUAL,
        CC_OTHER
    } char_class_t;

    typedef enum logic [1:0] {
        MK_NONE = 2'd0,
        MK_MUL  = 2'd1,
        MK_DIV  = 2'd2
    } mul_kind_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_DIG_MUL,
        CS_DIG_ADD,
        CS_TERM,
        CS_TERM_WAIT,
        CS_SUM,
        CS_EMIT,
        CS_FINISH
    } core_state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_RUN,
        MD_FIX
    } md_state_t;

    typedef struct packed {
        logic start;
        logic is_div;
    } md_req_t;

    typedef struct packed {
        logic done;
        logic div_zero;
    } md_resp_t;

    function automatic char_class_t char_class(input logic [7:0] ch);
        char_class_t c;
        if (ch >= CH_ZERO && ch <= CH_NINE)
        begin
            c = CC_DIGIT;
        end
        else if (ch == CH_STAR || ch == CH_SLASH)
        begin
            c = CC_MULDIV;
        end
        else if (ch == CH_PLUS || ch == CH_MINUS)
        begin
            c = CC_ADDSUB;
        end
        else if (ch == CH_EQUAL)
        begin
            c = CC_EQUAL;
        end
        else if (ch == CH_SPACE)
        begin
            c = CC_OTHER; // spaces are skipped
        end
        else
        begin
            c = CC_OTHER;
        end
        return c;
    endfunction

endpackage

// ===== rtl/iee_muldiv.sv =====
// iterative multiply and signed divide unit, one bit per cycle
`timescale 1ns / 1ps

module iee_muldiv #(
    parameter int WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  iee_pkg::md_req_t     req,
    input  logic [WIDTH-1:0]     op_a,
    input  logic [WIDTH-1:0]     op_b,
    output iee_pkg::md_resp_t    resp,
    output logic [WIDTH-1:0]     result
);

    localparam int CNT_W = $clog2(WIDTH);

    iee_pkg::md_state_t state_reg, state_next;
    logic [WIDTH-1:0]   acc_reg, acc_next;
    logic [WIDTH-1:0]   dvs_reg, dvs_next;
    logic [WIDTH-1:0]   sh_reg, sh_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               is_div_reg, is_div_next;
    logic               neg_reg, neg_next;
    logic               dz_reg, dz_next;

    logic [WIDTH-1:0]   mag_a, mag_b, trial, diff;
    logic               trial_ge, b_zero;

    assign mag_a    = op_a[WIDTH-1] ? (~op_a + WIDTH'(1)) : op_a;
    assign mag_b    = op_b[WIDTH-1] ? (~op_b + WIDTH'(1)) : op_b;
    assign b_zero   = (op_b == '0);
    // remainder stays below the divisor, so its top bit is always zero
    assign trial    = {acc_reg[WIDTH-2:0], sh_reg[WIDTH-1]};
    assign trial_ge = (trial >= dvs_reg);
    assign diff     = trial - dvs_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            iee_pkg::MD_IDLE:
            begin
                if (req.start)
                begin
                    state_next = (req.is_div && b_zero) ? iee_pkg::MD_FIX : iee_pkg::MD_RUN;
                end
            end
            iee_pkg::MD_RUN:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = iee_pkg::MD_FIX;
                end
            end
            iee_pkg::MD_FIX:
            begin
                state_next = iee_pkg::MD_IDLE;
            end
            default:
            begin
                state_next = iee_pkg::MD_IDLE;
            end
        endcase
    end

    always_comb
    begin
        acc_next    = acc_reg;
        dvs_next    = dvs_reg;
        sh_next     = sh_reg;
        cnt_next    = cnt_reg;
        is_div_next = is_div_reg;
        neg_next    = neg_reg;
        dz_next     = dz_reg;
        if (state_reg == iee_pkg::MD_IDLE && req.start)
        begin
            is_div_next = req.is_div;
            cnt_next    = CNT_W'(WIDTH - 1);
            acc_next    = '0;
            dz_next     = 1'b0;
            neg_next    = 1'b0;
            if (req.is_div)
            begin
                dvs_next = mag_b;
                sh_next  = mag_a;
                neg_next = op_a[WIDTH-1] ^ op_b[WIDTH-1];
                if (b_zero)
                begin
                    // quotient taken as zero
                    dz_next  = 1'b1;
                    sh_next  = '0;
                    neg_next = 1'b0;
                end
            end
            else
            begin
                dvs_next = op_a;
                sh_next  = op_b;
            end
        end
        else if (state_reg == iee_pkg::MD_RUN)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (is_div_reg)
            begin
                acc_next = trial_ge ? diff : trial;
                sh_next  = {sh_reg[WIDTH-2:0], trial_ge};
            end
            else
            begin
                if (sh_reg[0])
                begin
                    acc_next = acc_reg + dvs_reg;
                end
                dvs_next = {dvs_reg[WIDTH-2:0], 1'b0};
                sh_next  = {1'b0, sh_reg[WIDTH-1:1]};
            end
        end
    end

    assign resp.done     = (state_reg == iee_pkg::MD_FIX);
    assign resp.div_zero = dz_reg;
    assign result = is_div_reg ? (neg_reg ? (~sh_reg + WIDTH'(1)) : sh_reg) : acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= iee_pkg::MD_IDLE;
            cnt_reg    <= '0;
            is_div_reg <= 1'b0;
            neg_reg    <= 1'b0;
            dz_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            is_div_reg <= is_div_next;
            neg_reg    <= neg_next;
            dz_reg     <= dz_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        dvs_reg <= dvs_next;
        sh_reg  <= sh_next;
    end

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> state_reg == iee_pkg::MD_IDLE)
        else $error("operation started while unit busy");

    a_div_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (resp.done && resp.div_zero) |-> result == '0)
        else $error("divide by zero did not give zero");

endmodule

// ===== rtl/iee_core.sv =====
// character sequencer and expression state of the evaluator
`timescale 1ns / 1ps

module iee_core #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       in_char,
    input  logic             in_last,
    output logic             emit_valid,
    input  logic             emit_ready,
    output logic [WIDTH-1:0] emit_sum,
    output logic             emit_error
);

    iee_pkg::core_state_t state_reg, state_next;
    logic [WIDTH-1:0]     sum_reg, sum_next;
    logic [WIDTH-1:0]     term_reg, term_next;
    logic [WIDTH-1:0]     num_reg, num_next;
    logic                 sign_reg, sign_next;
    iee_pkg::mul_kind_t   kind_reg, kind_next;
    logic                 error_reg, error_next;
    logic                 result_given_reg, result_given_next;
    logic [7:0]           char_reg, char_next;
    logic                 last_reg, last_next;
    logic                 eol_phase_reg, eol_phase_next;
    logic                 emitted_reg, emitted_next;

    iee_pkg::char_class_t cls, in_cls;
    iee_pkg::core_state_t after_term;
    iee_pkg::md_req_t     md_req;
    iee_pkg::md_resp_t    md_resp;
    logic [WIDTH-1:0]     md_result;
    logic [3:0]           digit_code;
    logic                 accept, fire, term_closing;

    assign cls        = iee_pkg::char_class(char_reg);
    assign in_cls     = iee_pkg::char_class(in_char);
    assign in_ready   = (state_reg == iee_pkg::CS_IDLE);
    assign accept     = in_valid && in_ready;
    assign emit_valid = (state_reg == iee_pkg::CS_EMIT);
    assign emit_sum   = sum_reg;
    assign emit_error = error_reg;
    assign fire       = emit_valid && emit_ready;
    assign digit_code = 4'(char_reg - iee_pkg::CH_ZERO);

    assign md_req.start  = (state_reg == iee_pkg::CS_TERM) &&
                           (kind_reg == iee_pkg::MK_MUL || kind_reg == iee_pkg::MK_DIV);
    assign md_req.is_div = (kind_reg == iee_pkg::MK_DIV);

    iee_muldiv #(
        .WIDTH(WIDTH)
    ) u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (md_req),
        .op_a   (term_reg),
        .op_b   (num_reg),
        .resp   (md_resp),
        .result (md_result)
    );

    // a mul/div operator keeps the closed term; everything else goes on to the sum
    assign after_term = (eol_phase_reg || cls != iee_pkg::CC_MULDIV) ?
                        iee_pkg::CS_SUM : iee_pkg::CS_FINISH;

    assign term_closing = (state_reg == iee_pkg::CS_TERM && !md_req.start) ||
                          (state_reg == iee_pkg::CS_TERM_WAIT && md_resp.done);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            iee_pkg::CS_IDLE:
            begin
                if (accept && !result_given_reg)
                begin
                    unique case (in_cls)
                        iee_pkg::CC_DIGIT:
                        begin
                            state_next = iee_pkg::CS_DIG_MUL;
                        end
                        iee_pkg::CC_MULDIV, iee_pkg::CC_ADDSUB, iee_pkg::CC_EQUAL:
                        begin
                            state_next = iee_pkg::CS_TERM;
                        end
                        default:
                        begin
                            state_next = iee_pkg::CS_FINISH;
                        end
                    endcase
                end
            end
            iee_pkg::CS_DIG_MUL:
            begin
                state_next = iee_pkg::CS_DIG_ADD;
            end
            iee_pkg::CS_DIG_ADD:
            begin
                state_next = iee_pkg::CS_FINISH;
            end
            iee_pkg::CS_TERM:
            begin
                state_next = md_req.start ? iee_pkg::CS_TERM_WAIT : after_term;
            end
            iee_pkg::CS_TERM_WAIT:
            begin
                if (md_resp.done)
                begin
                    state_next = after_term;
                end
            end
            iee_pkg::CS_SUM:
            begin
                state_next = (eol_phase_reg || cls == iee_pkg::CC_EQUAL) ?
                             iee_pkg::CS_EMIT : iee_pkg::CS_FINISH;
            end
            iee_pkg::CS_EMIT:
            begin
                if (fire)
                begin
                    state_next = iee_pkg::CS_FINISH;
                end
            end
            iee_pkg::CS_FINISH:
            begin
                state_next = (last_reg && !emitted_reg) ? iee_pkg::CS_TERM : iee_pkg::CS_IDLE;
            end
            default:
            begin
                state_next = iee_pkg::CS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        sum_next          = sum_reg;
        term_next         = term_reg;
        num_next          = num_reg;
        sign_next         = sign_reg;
        kind_next         = kind_reg;
        error_next        = error_reg;
        result_given_next = result_given_reg;
        char_next         = char_reg;
        last_next         = last_reg;
        eol_phase_next    = eol_phase_reg;
        emitted_next      = emitted_reg;

        if (accept)
        begin
            char_next      = in_char;
            last_next      = in_last;
            eol_phase_next = 1'b0;
            emitted_next   = 1'b0;
            // after '=' only a line end matters, and the state is already clear
            if (result_given_reg && in_last)
            begin
                result_given_next = 1'b0;
            end
        end

        if (state_reg == iee_pkg::CS_DIG_MUL)
        begin
            num_next = {num_reg[WIDTH-4:0], 3'b000} + {num_reg[WIDTH-2:0], 1'b0};
        end

        if (state_reg == iee_pkg::CS_DIG_ADD)
        begin
            num_next = num_reg + WIDTH'(digit_code);
        end

        if (term_closing)
        begin
            if (state_reg == iee_pkg::CS_TERM_WAIT)
            begin
                term_next  = md_result;
                error_next = error_reg | md_resp.div_zero;
            end
            else
            begin
                term_next = num_reg;
            end
            num_next  = '0;
            kind_next = iee_pkg::MK_NONE;
            if (!eol_phase_reg && cls == iee_pkg::CC_MULDIV)
            begin
                kind_next = (char_reg == iee_pkg::CH_STAR) ? iee_pkg::MK_MUL : iee_pkg::MK_DIV;
            end
        end

        if (state_reg == iee_pkg::CS_SUM)
        begin
            sum_next  = sign_reg ? (sum_reg - term_reg) : (sum_reg + term_reg);
            term_next = '0;
            sign_next = 1'b0;
            if (!eol_phase_reg && cls == iee_pkg::CC_ADDSUB)
            begin
                sign_next = (char_reg == iee_pkg::CH_MINUS);
            end
        end

        if (fire)
        begin
            sum_next     = '0;
            term_next    = '0;
            num_next     = '0;
            sign_next    = 1'b0;
            kind_next    = iee_pkg::MK_NONE;
            error_next   = 1'b0;
            emitted_next = 1'b1;
            if (!eol_phase_reg)
            begin
                result_given_next = 1'b1;
            end
        end

        if (state_reg == iee_pkg::CS_FINISH && last_reg)
        begin
            if (!emitted_reg)
            begin
                // line end closes the expression and gives its result
                eol_phase_next = 1'b1;
            end
            else
            begin
                sum_next          = '0;
                term_next         = '0;
                num_next          = '0;
                sign_next         = 1'b0;
                kind_next         = iee_pkg::MK_NONE;
                error_next        = 1'b0;
                result_given_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= iee_pkg::CS_IDLE;
            sum_reg          <= '0;
            term_reg         <= '0;
            num_reg          <= '0;
            sign_reg         <= 1'b0;
            kind_reg         <= iee_pkg::MK_NONE;
            error_reg        <= 1'b0;
            result_given_reg <= 1'b0;
            last_reg         <= 1'b0;
            eol_phase_reg    <= 1'b0;
            emitted_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sum_reg          <= sum_next;
            term_reg         <= term_next;
            num_reg          <= num_next;
            sign_reg         <= sign_next;
            kind_reg         <= kind_next;
            error_reg        <= error_next;
            result_given_reg <= result_given_next;
            last_reg         <= last_next;
            eol_phase_reg    <= eol_phase_next;
            emitted_reg      <= emitted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
    end

    a_wait_leaves_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == iee_pkg::CS_TERM_WAIT && md_resp.done) |=>
        (state_reg == iee_pkg::CS_SUM || state_reg == iee_pkg::CS_FINISH))
        else $error("term close did not finish with the unit");

    a_eol_clears_given: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_last && result_given_reg) |=> !result_given_reg)
        else $error("line end after result did not rearm");

    a_emit_clears_expr: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (sum_reg == '0 && !error_reg && kind_reg == iee_pkg::MK_NONE))
        else $error("expression state not cleared after result");

endmodule

// ===== rtl/infix_integer_expression_evaluator_top.sv =====
// top level of the streaming infix integer expression evaluator
`timescale 1ns / 1ps
// a digit steps through the times-ten and add states before the core is ready again;
// an operator or '=' closes the term, waiting on the bit-serial mul/div unit if a '*' or '/'
// is pending, then adds it to the sum unless it is '*' or '/'; other characters are skipped;
// a line end adds one more term close and sum, again with the mul/div run if one is due
// one request is worked at a time; a result waits in the output register meanwhile
// reset (rst_n low, asynchronous) clears the expression, its flags and the output valid flag

module infix_integer_expression_evaluator_top #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,   // end_of_line
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] value
    output logic [0:0]  m_axis_tuser    // [0] div_error
);

    logic                         emit_valid, emit_ready, emit_error;
    logic [VALUE_WIDTH-1:0]       emit_sum;
    logic signed [63:0]           sum_ext;

    logic                         out_valid_reg, out_valid_next;
    logic [iee_pkg::OUT_WIDTH-1:0] out_data_reg, out_data_next;
    logic                         out_err_reg, out_err_next;

    iee_core #(
        .WIDTH(VALUE_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_char    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .emit_valid (emit_valid),
        .emit_ready (emit_ready),
        .emit_sum   (emit_sum),
        .emit_error (emit_error)
    );

    // sign-extend or truncate the sum to the 32-bit result field
    assign sum_ext = 64'($signed(emit_sum));

    // output register takes a new result when empty or being drained
    assign emit_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_err_next   = out_err_reg;
        if (emit_valid && emit_ready)
        begin
            out_valid_next = 1'b1;
            out_data_next  = sum_ext[iee_pkg::OUT_WIDTH-1:0];
            out_err_next   = emit_error;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_err_reg  <= out_err_next;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_err_reg;

endmodule

// ===== bench/infix_integer_expression_evaluator_top_tb.sv =====
// self-checking bench for the streaming infix integer expression evaluator
`timescale 1ns / 1ps

module infix_integer_expression_evaluator_top_tb;

    localparam int VW          = 32;
    localparam int RESET_CYC   = 9;
    localparam int HOLD_CYC    = 400;            // long receiver hold-off
    localparam int DRAIN_CYC   = 4 * (2 * VW + 12);
    localparam int STALL_LIMIT = 4000;           // cycles with no handshake at all

    // stimulus phases, each with its own idle pattern
    typedef enum int {
        PH_FREE,
        PH_PRESSURE,
        PH_SRC_IDLE,
        PH_SNK_STALL,
        PH_BOTH
    } phase_t;

    // request count at which each phase ends
    localparam int PHASE_END [5] = '{350, 420, 800, 1180, 1525};

    // directed row: character, line end, and an optional typed-in result
    typedef struct packed {
        logic [7:0]  ch;
        logic        eol;
        logic        fixed;
        logic [31:0] val;
        logic        err;
    } dir_row_t;

    localparam int DIR_ROWS = 24;
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        // empty line on a nul character
        '{8'h00,                    1'b1, 1'b1, 32'd0, 1'b0},
        // "9/0=" with the equal sign on the line end: divide by zero
        '{iee_pkg::CH_NINE,         1'b0, 1'b0, 32'd0, 1'b0},
        '{iee_pkg::CH_SLASH,        1'b0, 1'b0, 32'd0, 1'b0},
        '{iee_pkg::CH_ZERO,         1'b0, 1'b0, 32'd0, 1'b0},
        '{iee_pkg::CH_EQUAL,        1'b1, 1'b1, 32'd0, 1'b1},
        // "-3*-2=" leading minus and an operator with no number before it
        '{iee_pkg::CH_MINUS,        1'b0, 1'b0, 32'd0, 1'b0},
        '{iee_pkg::CH_ZERO + 8'd3,  1'b0, 1'b0, 32'd0, 1'b0},
        '{iee_pkg::CH_STAR,         1'b0, 1'b0, 32'd0, 1'b0},
        '{iee_pkg::CH_MINUS,        1'b0, 1'b0, 32'd0, 1'b0},
        '{iee_pkg::CH_ZERO + 8'd2,  1'b0, 1'b0, 32'd0, 1'b0},
        '{iee_pkg::CH_EQUAL,        1'b0, 1'b0, 32'd0, 1'b0},
        // characters after the equal sign, then a line end that gives nothing
        '{iee_pkg::CH_ZERO + 8'd5,  1'b0, 1'b0, 32'd0, 1'b0},
        '{8'hFF,                    1'b1, 1'b0, 32'd0, 1'b0},
        // "+1 2+<ff>4*6/4" leading plus, space and junk skipped, line end on a digit
        '{iee_pkg::CH_PLUS,         1'b0, 1'b0, 32'd0, 1'b0},
        '{iee_pkg::CH_ZERO + 8'd1,  1'b0, 1'b0, 32'd0, 1'b0},
        '{iee_pkg::CH_SPACE,        1'b0, 1'b0, 32'd0, 1'b0},
        '{iee_pkg::CH_ZERO + 8'd2,  1'b0, 1'b0, 32'd0, 1'b0},
        '{iee_pkg::CH_PLUS,         1'b0, 1'b0, 32'd0, 1'b0},
        '{8'hFF,                    1'b0, 1'b0, 32'd0, 1'b0},
        '{iee_pkg::CH_ZERO + 8'd4,  1'b0, 1'b0, 32'd0, 1'b0},
        '{iee_pkg::CH_STAR,         1'b0, 1'b0, 32'd0, 1'b0},
        '{iee_pkg::CH_ZERO + 8'd6,  1'b0, 1'b0, 32'd0, 1'b0},
        '{iee_pkg::CH_SLASH,        1'b0, 1'b0, 32'd0, 1'b0},
        '{iee_pkg::CH_ZERO + 8'd4,  1'b1, 1'b0, 32'd0, 1'b0}
    };

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // [7:0] char_code
    logic        s_axis_tlast;     // end_of_line
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;     // [31:0] value
    logic [0:0]  m_axis_tuser;     // [0] div_error

    // shadow copy of the evaluator state
    logic [VW-1:0]      sum_acc;
    logic [VW-1:0]      term_acc;
    logic [VW-1:0]      num_acc;
    logic               sub_next;
    iee_pkg::mul_kind_t mul_next;
    logic               zero_div_seen;
    logic               line_closed;

    // results still to come, oldest first
    logic [31:0] want_value_q [$];
    logic        want_div_err_q [$];

    // characters of the line being built
    logic [7:0] line_buf [$];

    phase_t phase;
    int     sent_count;
    int     fail_count;
    int     quiet_cycles;

    infix_integer_expression_evaluator_top #(
        .VALUE_WIDTH(VW)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // expression predictor
    // ------------------------------------------------------------------

    // quotient truncated toward zero; most negative by minus one wraps
    function automatic logic [VW-1:0] quot_trunc(input logic [VW-1:0] a,
                                                 input logic [VW-1:0] b);
        logic [VW-1:0] mag_a;
        logic [VW-1:0] mag_b;
        logic [VW-1:0] q;
        mag_a = a[VW-1] ? (~a + 1'b1) : a;
        mag_b = b[VW-1] ? (~b + 1'b1) : b;
        q = mag_a / mag_b;
        return (a[VW-1] ^ b[VW-1]) ? (~q + 1'b1) : q;
    endfunction

    task automatic clear_line();
        sum_acc       = '0;
        term_acc      = '0;
        num_acc       = '0;
        sub_next      = 1'b0;
        mul_next      = iee_pkg::MK_NONE;
        zero_div_seen = 1'b0;
    endtask

    // fold the pending number into the term
    task automatic fold_term();
        if (mul_next == iee_pkg::MK_MUL)
        begin
            term_acc = term_acc * num_acc;
        end
        else if (mul_next == iee_pkg::MK_DIV)
        begin
            if (num_acc == '0)
            begin
                zero_div_seen = 1'b1;
                term_acc = '0;
            end
            else
            begin
                term_acc = quot_trunc(term_acc, num_acc);
            end
        end
        else
        begin
            term_acc = num_acc;
        end
        num_acc  = '0;
        mul_next = iee_pkg::MK_NONE;
    endtask

    // fold the term into the running sum
    task automatic fold_sum();
        fold_term();
        sum_acc  = sub_next ? (sum_acc - term_acc) : (sum_acc + term_acc);
        term_acc = '0;
        sub_next = 1'b0;
    endtask

    // advance the shadow state by one character, report a result if one is due
    task automatic eval_char(input logic [7:0] ch, input logic eol,
                             output bit got, output logic [31:0] val,
                             output logic err);
        got = 1'b0;
        val = '0;
        err = 1'b0;
        if (!line_closed)
        begin
            if (ch >= iee_pkg::CH_ZERO && ch <= iee_pkg::CH_NINE)
            begin
                num_acc = num_acc * 10 + VW'(ch - iee_pkg::CH_ZERO);
            end
            else if (ch == iee_pkg::CH_STAR || ch == iee_pkg::CH_SLASH)
            begin
                fold_term();
                mul_next = (ch == iee_pkg::CH_STAR) ? iee_pkg::MK_MUL : iee_pkg::MK_DIV;
            end
            else if (ch == iee_pkg::CH_PLUS || ch == iee_pkg::CH_MINUS)
            begin
                fold_sum();
                sub_next = (ch == iee_pkg::CH_MINUS);
            end
            else if (ch == iee_pkg::CH_EQUAL)
            begin
                fold_sum();
                got = 1'b1;
                val = 32'(signed'(sum_acc));
                err = zero_div_seen;
                clear_line();
                line_closed = 1'b1;
            end
            if (eol && !got)
            begin
                fold_sum();
                got = 1'b1;
                val = 32'(signed'(sum_acc));
                err = zero_div_seen;
            end
        end
        if (eol)
        begin
            clear_line();
            line_closed = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    function automatic int src_idle_pct();
        case (phase)
            PH_SRC_IDLE: return 59;
            PH_BOTH:     return 7;
            default:     return 0;
        endcase
    endfunction

    function automatic int snk_stall_pct();
        case (phase)
            PH_SNK_STALL: return 59;
            PH_BOTH:      return 7;
            default:      return 0;
        endcase
    endfunction

    // offer one request, wait for it to be taken, then predict its result;
    // a row with a typed-in result is checked against that value instead
    task automatic send_item(input logic [7:0] ch, input logic eol,
                             input logic fixed, input logic [31:0] fval,
                             input logic ferr);
        bit          taken;
        bit          got;
        logic [31:0] pval;
        logic        perr;
        // idle gaps: valid drops only in cycles where no request is offered
        while ($urandom_range(0, 99) < src_idle_pct())
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= eol;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = s_axis_tready;
        end
        sent_count++;
        eval_char(ch, eol, got, pval, perr);
        if (got)
        begin
            want_value_q.push_back(fixed ? fval : pval);
            want_div_err_q.push_back(fixed ? ferr : perr);
        end
    endtask

    task automatic send_buf();
        for (int i = 0; i < line_buf.size(); i++)
        begin
            send_item(line_buf[i], i == line_buf.size() - 1, 1'b0, '0, 1'b0);
        end
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            line_buf.push_back(s[i]);
        end
    endtask

    task automatic maybe_space();
        if ($urandom_range(0, 99) < 15)
        begin
            line_buf.push_back(iee_pkg::CH_SPACE);
        end
    endtask

    // mostly short numbers, sometimes long ones that wrap
    task automatic push_number(input bit as_zero);
        int pick;
        int ndig;
        pick = $urandom_range(0, 99);
        if (as_zero)
        begin
            ndig = 0;
            line_buf.push_back(iee_pkg::CH_ZERO);
        end
        else if (pick < 80)
        begin
            ndig = $urandom_range(1, 3);
        end
        else if (pick < 95)
        begin
            ndig = $urandom_range(4, 6);
        end
        else
        begin
            ndig = $urandom_range(7, 11);
        end
        repeat (ndig)
        begin
            line_buf.push_back(iee_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        end
    endtask

    // well-formed expression with random numbers and operators
    task automatic build_expr();
        int         pick;
        int         nops;
        logic [7:0] op;
        pick = $urandom_range(0, 3);
        if (pick == 1)
        begin
            line_buf.push_back(iee_pkg::CH_MINUS);
        end
        else if (pick == 2)
        begin
            line_buf.push_back(iee_pkg::CH_PLUS);
        end
        maybe_space();
        push_number(1'b0);
        nops = $urandom_range(0, 5);
        repeat (nops)
        begin
            maybe_space();
            case ($urandom_range(0, 3))
                0:       op = iee_pkg::CH_PLUS;
                1:       op = iee_pkg::CH_MINUS;
                2:       op = iee_pkg::CH_STAR;
                default: op = iee_pkg::CH_SLASH;
            endcase
            line_buf.push_back(op);
            maybe_space();
            push_number(op == iee_pkg::CH_SLASH && $urandom_range(0, 7) == 0);
        end
    endtask

    // one line of stimulus: mostly well-formed, the rest broken or noise
    task automatic send_line();
        string tokens;
        int    kind;
        int    len;
        tokens = "0123456789+-*/= ";
        line_buf.delete();
        kind = $urandom_range(0, 99);
        if (kind < 70)
        begin
            build_expr();
            case ($urandom_range(0, 3))
                0:
                begin
                    line_buf.push_back(iee_pkg::CH_EQUAL);
                end
                1:
                begin
                    // line end lands on the last character itself
                end
                2:
                begin
                    // junk after the equal sign is skipped up to the line end
                    line_buf.push_back(iee_pkg::CH_EQUAL);
                    repeat ($urandom_range(1, 4))
                    begin
                        line_buf.push_back(8'($urandom_range(0, 255)));
                    end
                end
                default:
                begin
                    line_buf.push_back(iee_pkg::CH_SPACE);
                end
            endcase
            send_buf();
        end
        else if (kind < 75)
        begin
            // most negative divided by minus one
            push_text("2147483648");
            line_buf.push_back(iee_pkg::CH_SLASH);
            push_text("4294967295");
            if ($urandom_range(0, 1) == 1)
            begin
                line_buf.push_back(iee_pkg::CH_EQUAL);
            end
            send_buf();
        end
        else if (kind < 87)
        begin
            // broken sequences: operators back to back, stray equal signs
            len = $urandom_range(1, 12);
            repeat (len)
            begin
                line_buf.push_back(tokens[$urandom_range(0, tokens.len() - 1)]);
            end
            send_buf();
        end
        else
        begin
            // raw bytes with line ends scattered through them
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
            begin
                send_item(8'($urandom_range(0, 255)),
                          (i == len - 1) || ($urandom_range(0, 5) == 0),
                          1'b0, '0, 1'b0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // receiver: random stalls per phase, plus one long hold-off so the
    // output register fills and the request side backs up
    initial
    begin
        bit held;
        held = 1'b0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (phase == PH_PRESSURE && !held)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYC) @(posedge clk);
                held = 1'b1;
            end
            m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct());
        end
    end

    // compare every result taken with the oldest prediction
    always @(posedge clk)
    begin : result_check
        logic [31:0] want_val;
        logic        want_err;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (want_value_q.size() == 0)
            begin
                $error("result with none pending: value %0d div_error %0b",
                       $signed(m_axis_tdata), m_axis_tuser[0]);
                fail_count++;
            end
            else
            begin
                want_val = want_value_q.pop_front();
                want_err = want_div_err_q.pop_front();
                if (m_axis_tdata !== want_val)
                begin
                    $error("value: expected %0d, actual %0d",
                           $signed(want_val), $signed(m_axis_tdata));
                    fail_count++;
                end
                if (m_axis_tuser[0] !== want_err)
                begin
                    $error("div_error: expected %0b, actual %0b",
                           want_err, m_axis_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        phase         = PH_FREE;
        sent_count    = 0;
        fail_count    = 0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        clear_line();
        line_closed = 1'b0;
        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table first
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            send_item(DIR_TAB[i].ch, DIR_TAB[i].eol, DIR_TAB[i].fixed,
                      DIR_TAB[i].val, DIR_TAB[i].err);
        end

        // random lines, phase by phase
        for (int p = 0; p < 5; p++)
        begin
            phase = phase_t'(p);
            while (sent_count < PHASE_END[p])
            begin
                send_line();
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain, then let the block settle
        wait (want_value_q.size() == 0);
        repeat (DRAIN_CYC) @(posedge clk);
        if (want_value_q.size() != 0)
        begin
            $error("%0d results never arrived", want_value_q.size());
            fail_count++;
        end
        if (fail_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== infix_integer_expression_evaluator_top.f =====
rtl/iee_pkg.sv
rtl/iee_muldiv.sv
rtl/iee_core.sv
rtl/infix_integer_expression_evaluator_top.sv
bench/infix_integer_expression_evaluator_top_tb.sv
